// ===== hdl/assert_macros.svh =====
// Assertion macros used by the limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/twl_pkg.sv =====
// Types, register indexes and arithmetic step functions for the twist/wrench limiter.
package twl_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_TWIST_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWIST_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRENCH_A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRENCH_B  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRENCH_C  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORM      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd7;

  typedef struct packed {
    logic signed [31:0] lin_vel_x;
    logic signed [31:0] lin_vel_y;
    logic signed [31:0] lin_vel_z;
    logic signed [31:0] ang_vel_x;
    logic signed [31:0] ang_vel_y;
    logic signed [31:0] ang_vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_lin_vel_x;
    logic signed [31:0] out_lin_vel_y;
    logic signed [31:0] out_lin_vel_z;
    logic signed [31:0] out_ang_vel_x;
    logic signed [31:0] out_ang_vel_y;
    logic signed [31:0] out_ang_vel_z;
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
    logic signed [31:0] out_force_z;
    logic signed [31:0] out_torque_x;
    logic signed [31:0] out_torque_y;
    logic signed [31:0] out_torque_z;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [31:0] m;
    logic [31:0] l;
  } cand_t;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // one restoring quotient bit; upper half of w must be below d
  function automatic logic [63:0] div_step(input logic [63:0] w, input logic [31:0] d);
    logic [64:0] t;
    logic [32:0] hi;
    t  = {w, 1'b0};
    hi = t[64:32];
    if (hi >= {1'b0, d}) begin
      t[64:32] = hi - {1'b0, d};
      t[0]     = 1'b1;
    end
    return t[63:0];
  endfunction

  // one root bit per call
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       o;
    logic [35:0] r;
    logic [35:0] trial;
    r     = {s.rem, s.x[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      r      = r - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.root = {s.root[30:0], 1'b0};
    end
    o.rem = r[33:0];
    o.x   = {s.x[61:0], 2'b00};
    return o;
  endfunction

  function automatic cand_t pick(input cand_t a, input cand_t b,
                                 input logic [63:0] pa, input logic [63:0] pb);
    if (b.en && (!a.en || pb > pa)) return b;
    return a;
  endfunction

endpackage

// ===== hdl/twist_wrench_limiter.sv =====
// Twist/wrench limiter: twist ratio scaling, wrench clamp and norm scaling, pipelined.
// Throughput: one transaction per cycle while the output is not stalled; depth set by the 32-stage square root
// followed by the 32-stage divider applied to all twelve lanes.
// A stalled output holds the whole pipeline.
// Reset clears all stage valid bits and every limit register to zero.
`include "assert_macros.svh"
module twist_wrench_limiter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  twl_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output twl_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data
);
  import twl_pkg::*;

  localparam int LAST = 68;

  logic [6:0][63:0] cfg_r;
  logic [31:0]      eps;

  logic [LAST:0] vld;
  logic          en;

  in_item_t    in_q;
  logic [31:0] in_arr [LANES];

  logic [31:0]      mag_p [1:36][LANES];
  logic [LANES-1:0] neg_p [1:LAST];

  cand_t       c1 [6];
  cand_t       c2 [6];
  logic [63:0] pa2 [3];
  logic [63:0] pb2 [3];
  cand_t       w3 [3];
  cand_t       c4 [3];
  logic [63:0] pa4, pb4, pa6, pb6;
  cand_t       w5 [2];
  cand_t       c6 [2];
  cand_t       kp [7:36];

  logic [63:0] sq2 [6];
  logic [63:0] lsq2 [2];
  logic        scale_p [3:36][2];
  sqrt_t       sq_p [4:35][2];
  logic [31:0] root_q [2];

  logic [63:0] divw [36:LAST][LANES];
  logic [31:0] divd [36:LAST][3];

  assign en        = !(vld[LAST] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAST];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= '0;
      eps   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TWIST_A:  cfg_r[0] <= cfg_data;
        REG_TWIST_B:  cfg_r[1] <= cfg_data;
        REG_TWIST_C:  cfg_r[2] <= cfg_data;
        REG_WRENCH_A: cfg_r[3] <= cfg_data;
        REG_WRENCH_B: cfg_r[4] <= cfg_data;
        REG_WRENCH_C: cfg_r[5] <= cfg_data;
        REG_NORM:     cfg_r[6] <= cfg_data;
        REG_EPSILON:  eps      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  always_comb begin
    in_arr[0]  = in_q.lin_vel_x;
    in_arr[1]  = in_q.lin_vel_y;
    in_arr[2]  = in_q.lin_vel_z;
    in_arr[3]  = in_q.ang_vel_x;
    in_arr[4]  = in_q.ang_vel_y;
    in_arr[5]  = in_q.ang_vel_z;
    in_arr[6]  = in_q.force_x;
    in_arr[7]  = in_q.force_y;
    in_arr[8]  = in_q.force_z;
    in_arr[9]  = in_q.torque_x;
    in_arr[10] = in_q.torque_y;
    in_arr[11] = in_q.torque_z;
  end

  always_ff @(posedge clk) begin
    logic [31:0] m;
    logic [31:0] l;
    logic [31:0] lim;
    logic [63:0] s;
    sqrt_t       s0;
    if (en) begin
      in_q <= in_data;

      // magnitudes, twist candidates, wrench clamp
      for (int i = 0; i < LANES; i++) begin
        m = in_arr[i][31] ? (32'd0 - in_arr[i]) : in_arr[i];
        neg_p[1][i] <= in_arr[i][31];
        if (i < 6) begin
          l = cfg_r[i >> 1][(i & 1) * 32 +: 32];
          c1[i] <= '{en: (l > eps) && (m > l), m: m, l: l};
          mag_p[1][i] <= m;
        end else begin
          l = cfg_r[3 + ((i - 6) >> 1)][((i - 6) & 1) * 32 +: 32];
          mag_p[1][i] <= ((l > eps) && (m > l)) ? l : m;
        end
      end
      for (int s_i = 2; s_i <= 36; s_i++) mag_p[s_i] <= mag_p[s_i-1];
      for (int s_i = 2; s_i <= LAST; s_i++) neg_p[s_i] <= neg_p[s_i-1];

      // ratio tournament, lower axis wins ties
      for (int j = 0; j < 3; j++) begin
        pa2[j] <= {32'd0, c1[2*j].m} * {32'd0, c1[2*j+1].l};
        pb2[j] <= {32'd0, c1[2*j+1].m} * {32'd0, c1[2*j].l};
      end
      c2 <= c1;
      for (int j = 0; j < 3; j++) w3[j] <= pick(c2[2*j], c2[2*j+1], pa2[j], pb2[j]);
      pa4 <= {32'd0, w3[0].m} * {32'd0, w3[1].l};
      pb4 <= {32'd0, w3[1].m} * {32'd0, w3[0].l};
      c4  <= w3;
      w5[0] <= pick(c4[0], c4[1], pa4, pb4);
      w5[1] <= c4[2];
      pa6 <= {32'd0, w5[0].m} * {32'd0, w5[1].l};
      pb6 <= {32'd0, w5[1].m} * {32'd0, w5[0].l};
      c6  <= w5;
      kp[7] <= pick(c6[0], c6[1], pa6, pb6);
      for (int s_i = 8; s_i <= 36; s_i++) kp[s_i] <= kp[s_i-1];

      // wrench sums of squares
      for (int i = 0; i < 6; i++)
        sq2[i] <= {32'd0, mag_p[1][6+i]} * {32'd0, mag_p[1][6+i]};
      for (int g = 0; g < 2; g++)
        lsq2[g] <= {32'd0, cfg_r[6][g*32 +: 32]} * {32'd0, cfg_r[6][g*32 +: 32]};
      for (int g = 0; g < 2; g++) begin
        s   = sq2[3*g] + sq2[3*g+1] + sq2[3*g+2];
        lim = cfg_r[6][g*32 +: 32];
        scale_p[3][g] <= (lim > eps) && (s > lsq2[g]);
        s0 = '{x: s, rem: 34'd0, root: 32'd0};
        sq_p[4][g] <= sqrt_step(s0);
      end
      for (int s_i = 4; s_i <= 36; s_i++) scale_p[s_i] <= scale_p[s_i-1];
      for (int s_i = 5; s_i <= 35; s_i++)
        for (int g = 0; g < 2; g++) sq_p[s_i][g] <= sqrt_step(sq_p[s_i-1][g]);

      // root is one stage ahead of the lane data; realign
      for (int g = 0; g < 2; g++) root_q[g] <= sq_p[35][g].root;

      // numerators and divisors
      for (int i = 0; i < 6; i++)
        divw[36][i] <= {32'd0, mag_p[35][i]} *
                       {32'd0, (kp[35].en ? kp[35].l : 32'd1)};
      divd[36][0] <= kp[35].en ? kp[35].m : 32'd1;
      for (int g = 0; g < 2; g++) begin
        lim = scale_p[35][g] ? cfg_r[6][g*32 +: 32] : 32'd1;
        for (int i = 0; i < 3; i++)
          divw[36][6+3*g+i] <= {32'd0, mag_p[35][6+3*g+i]} * {32'd0, lim};
        divd[36][1+g] <= scale_p[35][g] ? root_q[g] : 32'd1;
      end

      for (int s_i = 37; s_i <= LAST; s_i++) begin
        divd[s_i] <= divd[s_i-1];
        for (int i = 0; i < LANES; i++)
          divw[s_i][i] <= div_step(divw[s_i-1][i],
                                   divd[s_i-1][(i < 6) ? 0 : ((i < 9) ? 1 : 2)]);
      end
    end
  end

  logic [31:0] res [LANES];
  always_comb begin
    for (int i = 0; i < LANES; i++)
      res[i] = neg_p[LAST][i] ? (32'd0 - divw[LAST][i][31:0]) : divw[LAST][i][31:0];
    out_data.out_lin_vel_x = res[0];
    out_data.out_lin_vel_y = res[1];
    out_data.out_lin_vel_z = res[2];
    out_data.out_ang_vel_x = res[3];
    out_data.out_ang_vel_y = res[4];
    out_data.out_ang_vel_z = res[5];
    out_data.out_force_x   = res[6];
    out_data.out_force_y   = res[7];
    out_data.out_force_z   = res[8];
    out_data.out_torque_x  = res[9];
    out_data.out_torque_y  = res[10];
    out_data.out_torque_z  = res[11];
  end

  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_ALWAYS(a_twist_exceeds, clk, rst, !(vld[7] && kp[7].en) || (kp[7].m > kp[7].l))
  `ASSERT_ALWAYS(a_div_twist, clk, rst, !vld[37] || (divw[37][0][63:32] < divd[37][0]))
  `ASSERT_ALWAYS(a_div_force, clk, rst, !vld[37] || (divw[37][6][63:32] < divd[37][1]))

endmodule
